// ----- design/assert_macros.svh -----
// assertion macros shared by the blind motor controller rtl
// clocked on clk, reset is the active-low rst_n of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpmc assertion failed");
`define BPMC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bpmc assertion failed");
`else
`define BPMC_ASSERT(label, prop)
`define BPMC_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- design/bpmc_pkg.sv -----
// types and constants for the blind position motor controller
// no dependencies
`timescale 1ns / 1ps

package bpmc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int POS_W     = 7;
  localparam int ACC_W     = POS_W + FRAC_BITS;
  localparam int STEP_W    = 31;
  localparam int REQ_W     = 8;
  localparam int SUM_W     = 33;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [POS_W-1:0]  PCT_FULL   = POS_W'(100);
  localparam logic [POS_W-1:0]  PCT_EMPTY  = '0;
  localparam logic [ACC_W-1:0]  FULL_SCALE = ACC_W'(PCT_FULL) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(559241);

  // register index, taken from paddr[2]
  localparam logic REG_OPEN_STEP  = 1'b0;
  localparam logic REG_CLOSE_STEP = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_MOVE = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [REQ_W-1:0] requested_position;
  } in_t;

  typedef struct packed {
    logic             motor_up;
    logic             motor_down;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] target;
    logic             report;
  } out_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [ACC_W-1:0] acc;
    logic [POS_W-1:0] goal;
    logic             moving;
    logic             moving_up;
    logic [POS_W-1:0] start;
    logic             first_pending;
  } ctl_state_t;

endpackage

// ----- design/bpmc_step.sv -----
// next-state and result logic for one beat of the blind motor controller
// depends on bpmc_pkg
`timescale 1ns / 1ps

module bpmc_step (
  input  bpmc_pkg::ctl_state_t            cur,
  input  bpmc_pkg::in_t                   item,
  input  logic [bpmc_pkg::STEP_W-1:0]     open_step,
  input  logic [bpmc_pkg::STEP_W-1:0]     close_step,
  output bpmc_pkg::ctl_state_t            nxt,
  output bpmc_pkg::out_t                  res
);
  import bpmc_pkg::*;

  logic [SUM_W-1:0] sum_up;
  logic [SUM_W-1:0] diff_dn;
  logic [ACC_W-1:0] acc_up;
  logic [ACC_W-1:0] acc_dn;
  logic [ACC_W-1:0] acc_tick;
  logic [POS_W-1:0] pos_tick;
  logic [POS_W-1:0] req_clamped;
  logic             reached;

  // travel arithmetic, saturating to 0..100.0
  assign sum_up   = SUM_W'(cur.acc) + SUM_W'(open_step);
  assign diff_dn  = SUM_W'(cur.acc) - SUM_W'(close_step);
  assign acc_up   = (sum_up > SUM_W'(FULL_SCALE)) ? FULL_SCALE : sum_up[ACC_W-1:0];
  assign acc_dn   = (SUM_W'(close_step) >= SUM_W'(cur.acc)) ? '0 : diff_dn[ACC_W-1:0];
  assign acc_tick = cur.moving_up ? acc_up : acc_dn;
  assign pos_tick = acc_tick[ACC_W-1 -: POS_W];
  assign reached  = cur.moving_up ? (pos_tick >= cur.goal) : (pos_tick <= cur.goal);

  assign req_clamped = (item.requested_position > REQ_W'(PCT_FULL)) ?
                       PCT_FULL : item.requested_position[POS_W-1:0];

  always_comb begin
    logic             do_move;
    logic [POS_W-1:0] goal;
    logic             report;
    nxt     = cur;
    do_move = 1'b0;
    goal    = cur.goal;
    report  = 1'b0;

    unique case (item.op) inside
      OP_TICK: begin
        if (cur.moving) begin
          nxt.acc = acc_tick;
          nxt.pos = pos_tick;
          if (cur.first_pending && (pos_tick != cur.start)) begin
            nxt.first_pending = 1'b0;
            report            = 1'b1;
          end
          if (reached) begin
            nxt.moving        = 1'b0;
            nxt.first_pending = 1'b0;
            nxt.pos           = cur.goal;
            report            = 1'b1;
          end
        end
      end
      OP_UP, OP_DOWN: begin
        do_move = 1'b1;
        report  = 1'b1;
        // a button stops a running move, else it heads for an end stop
        if (cur.pos != cur.goal) begin
          goal = cur.pos;
        end else begin
          goal = (item.op == OP_UP) ? PCT_FULL : PCT_EMPTY;
        end
      end
      OP_MOVE: begin
        do_move = 1'b1;
        goal    = req_clamped;
        report  = (cur.pos == req_clamped);
      end
    endcase

    if (do_move) begin
      nxt.goal = goal;
      nxt.acc  = ACC_W'(cur.pos) << FRAC_BITS;
      if (cur.pos == goal) begin
        nxt.moving        = 1'b0;
        nxt.first_pending = 1'b0;
      end else begin
        nxt.moving        = 1'b1;
        nxt.moving_up     = (cur.pos < goal);
        nxt.start         = cur.pos;
        nxt.first_pending = 1'b1;
      end
    end

    res.motor_up   = nxt.moving && nxt.moving_up;
    res.motor_down = nxt.moving && !nxt.moving_up;
    res.position   = nxt.pos;
    res.target     = nxt.goal;
    res.report     = report;
  end

endmodule

// ----- design/blind_position_motor_controller_core.sv -----
// top level of the blind position motor controller
// depends on bpmc_pkg, bpmc_step and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Drives the up and down motor of a window blind and tracks its position in
// percent from travel time. Input beats on in_data carry an op (tick, up
// button, down button, move to target) and a requested position; every input
// beat yields exactly one result beat on out_data with motor drive, position,
// target and a report flag for the host.
// Both channels use valid/stall: a beat moves when valid is high and stall is
// low. An accepted beat is held in an input register, worked on by the step
// logic and written to the output register once that register is free.
// One beat per cycle is sustained while the receiver does not stall; the
// step logic is one 33-bit add or subtract with compares.
// When the receiver stalls, the output holds its beat and the input register
// still takes one more beat; in_stall rises only when both are full.
// open_step and close_step are written over the APB port (byte 0 and 4); the
// user must write them only while the block is idle, and the block itself
// does not enforce it. Synchronous reset clears position, target and motion
// state, empties both registers and loads both steps with 559241.
module blind_position_motor_controller_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpmc_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bpmc_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpmc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpmc_pkg::DATA_W-1:0] pwdata,
  output logic [bpmc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bpmc_pkg::*;

  logic [STEP_W-1:0] open_step_r;
  logic [STEP_W-1:0] close_step_r;
  logic              s1_valid_r;
  in_t               s1_data_r;
  logic              out_valid_r;
  out_t              out_data_r;
  ctl_state_t        state_r;
  ctl_state_t        state_nxt;
  out_t              res_nxt;
  logic              advance;
  logic              cfg_wr;

  // output register frees up when empty or taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLOSE_STEP) ? DATA_W'(close_step_r) :
                                                 DATA_W'(open_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_step_r  <= STEP_RESET;
      close_step_r <= STEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_OPEN_STEP:  open_step_r  <= pwdata[STEP_W-1:0];
        REG_CLOSE_STEP: close_step_r <= pwdata[STEP_W-1:0];
      endcase
    end
  end

  bpmc_step u_step (
    .cur        (state_r),
    .item       (s1_data_r),
    .open_step  (open_step_r),
    .close_step (close_step_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BPMC_ASSERT(a_pos_range, state_r.pos <= PCT_FULL && state_r.goal <= PCT_FULL)
  `BPMC_ASSERT(a_acc_range, state_r.moving |-> state_r.acc <= FULL_SCALE)
  `BPMC_ASSERT(a_pending_idle, !state_r.moving |-> !state_r.first_pending)
  `BPMC_ASSERT(a_stall_full, in_stall |-> s1_valid_r && out_valid_r && out_stall)
  `BPMC_ASSERT(a_motor_excl, out_valid_r |-> !(out_data_r.motor_up && out_data_r.motor_down))
  `BPMC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule

// ----- tb/tb_blind_position_motor_controller_core.sv -----
// testbench for blind_position_motor_controller_core: directed and random command
// beats, each status beat checked against a behavioral blind travel predictor
// depends on bpmc_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_blind_position_motor_controller_core;
  import bpmc_pkg::*;

  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(1677721600);
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 84;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  blind_position_motor_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the blind state and step registers
  logic [STEP_W-1:0] up_step;
  logic [STEP_W-1:0] down_step;
  logic [POS_W-1:0]  pos_pct;
  logic [POS_W-1:0]  goal_pct;
  logic [POS_W-1:0]  start_pct;
  logic [31:0]       travel_acc;
  logic              running;
  logic              running_up;
  logic              first_change_armed;

  in_t  pending_cmd_q[$];
  out_t predicted_status_q[$];
  out_t want_status;

  int cmds_queued  = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int mismatches   = 0;
  int reg_writes   = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int mode_left    = 0;
  int hold_left    = 0;
  int holds_done   = 0;
  int quiet_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // store the goal and reload the accumulator; returns the report bit
  function automatic logic aim_blind(input logic [REQ_W-1:0] req);
    logic [POS_W-1:0] g;
    g = (req > {1'b0, PCT_FULL}) ? PCT_FULL : req[POS_W-1:0];
    goal_pct   = g;
    travel_acc = {25'd0, pos_pct} << FRAC_BITS;
    if (pos_pct == g) begin
      running            = 1'b0;
      first_change_armed = 1'b0;
      return 1'b1;
    end
    running            = 1'b1;
    running_up         = pos_pct < g;
    start_pct          = pos_pct;
    first_change_armed = 1'b1;
    return 1'b0;
  endfunction

  function automatic out_t blind_status(input in_t beat);
    logic [63:0] acc_next;
    logic        rep;
    out_t        res;
    rep = 1'b0;
    case (beat.op)
      OP_TICK: if (running) begin
        if (running_up) begin
          acc_next = {32'd0, travel_acc} + {33'd0, up_step};
          if (acc_next > {33'd0, FULL_SCALE}) acc_next = {33'd0, FULL_SCALE};
        end else if ({33'd0, down_step} >= {32'd0, travel_acc}) begin
          acc_next = '0;
        end else begin
          acc_next = {32'd0, travel_acc} - {33'd0, down_step};
        end
        travel_acc = acc_next[31:0];
        pos_pct    = acc_next[FRAC_BITS +: POS_W];
        if (first_change_armed && pos_pct != start_pct) begin
          first_change_armed = 1'b0;
          rep                = 1'b1;
        end
        if (running_up ? (pos_pct >= goal_pct) : (pos_pct <= goal_pct)) begin
          running            = 1'b0;
          first_change_armed = 1'b0;
          pos_pct            = goal_pct;
          rep                = 1'b1;
        end
      end
      OP_UP, OP_DOWN: begin
        // away from target the button stops in place, else it runs to an end
        if (pos_pct != goal_pct) void'(aim_blind({1'b0, pos_pct}));
        else if (beat.op == OP_UP) void'(aim_blind({1'b0, PCT_FULL}));
        else void'(aim_blind({1'b0, PCT_EMPTY}));
        rep = 1'b1;
      end
      default: rep = aim_blind(beat.requested_position);
    endcase
    res.motor_up   = running && running_up;
    res.motor_down = running && !running_up;
    res.position   = pos_pct;
    res.target     = goal_pct;
    res.report     = rep;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("status beat %0d %s got %0d want %0d",
                              results_seen, name, got, want));
  endtask

  task automatic queue_cmd(input op_t op, input logic [REQ_W-1:0] req);
    in_t beat;
    beat.op                 = op;
    beat.requested_position = req;
    pending_cmd_q.push_back(beat);
    cmds_queued++;
  endtask

  task automatic write_step(input logic idx, input logic [STEP_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!pready) flag_mismatch("pready low in access phase");
    if (idx == REG_OPEN_STEP) up_step = val;
    else down_step = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    // read back once the write has landed
    @(posedge clk);
    if (prdata != {1'b0, val})
      flag_mismatch($sformatf("step register %0d read back %0h", idx, prdata));
  endtask

  // wait until every queued command has produced its status beat
  task automatic wait_drained();
    while (results_seen < cmds_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_target();
    if ($urandom_range(0, 3) != 0) return REQ_W'($urandom_range(0, 100));
    return REQ_W'($urandom_range(0, 255));
  endfunction

  // mostly a move or button followed by a run of ticks, some loose beats
  task automatic queue_travel(input int n_beats);
    int first;
    int ticks;
    int k;
    first = cmds_queued;
    while (cmds_queued - first < n_beats) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_cmd(OP_MOVE, pick_target());
        6: queue_cmd(OP_UP, REQ_W'($urandom_range(0, 255)));
        7: queue_cmd(OP_DOWN, REQ_W'($urandom_range(0, 255)));
        default: queue_cmd(op_t'($urandom_range(0, 3)), REQ_W'($urandom_range(0, 255)));
      endcase
      ticks = $urandom_range(0, 30);
      for (k = 0; k < ticks; k++) begin
        if ($urandom_range(0, 39) == 0)
          queue_cmd($urandom_range(0, 1) ? OP_UP : OP_DOWN, REQ_W'($urandom_range(0, 255)));
        else
          queue_cmd(OP_TICK, REQ_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_status_q.push_back(blind_status(in_data));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_cmd_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_data  <= pending_cmd_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall pattern in segments, plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ((holds_done == 0 && beats_in >= 160) ||
                 (holds_done == 1 && beats_in >= 520)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // monitor: each status beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_status_q.size() == 0) begin
        flag_mismatch($sformatf("status beat %0d with no command outstanding", results_seen));
      end else begin
        want_status = predicted_status_q.pop_front();
        compare_field("motor_up", int'(out_data.motor_up), int'(want_status.motor_up));
        compare_field("motor_down", int'(out_data.motor_down),
                      int'(want_status.motor_down));
        compare_field("position", int'(out_data.position), int'(want_status.position));
        compare_field("target", int'(out_data.target), int'(want_status.target));
        compare_field("report", int'(out_data.report), int'(want_status.report));
        if (want_status.report) reports_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    logic [STEP_W-1:0] o_step;
    logic [STEP_W-1:0] c_step;
    up_step            = STEP_RESET;
    down_step          = STEP_RESET;
    pos_pct            = '0;
    goal_pct           = '0;
    start_pct          = '0;
    travel_acc         = '0;
    running            = 1'b0;
    running_up         = 1'b0;
    first_change_armed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset step values: idle tick, clamped targets, buttons both ways
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_MOVE, 8'd0);
    queue_cmd(OP_MOVE, 8'd255);
    queue_cmd(OP_TICK, 8'd255);
    queue_cmd(OP_DOWN, 8'd0);
    queue_cmd(OP_MOVE, 8'd101);
    queue_cmd(OP_DOWN, 8'd255);
    queue_cmd(OP_DOWN, 8'd0);
    queue_cmd(OP_UP, 8'd0);
    queue_cmd(OP_UP, 8'd0);
    wait_drained();

    // full-scale steps: saturation both ways, first change and arrival together
    write_step(REG_OPEN_STEP, STEP_MAX);
    write_step(REG_CLOSE_STEP, STEP_MAX);
    queue_cmd(OP_MOVE, 8'd100);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_MOVE, 8'd0);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_MOVE, 8'd50);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_MOVE, 8'd127);
    queue_cmd(OP_TICK, 8'd0);
    wait_drained();

    // zero step upward never advances, smallest step downward drops one percent
    write_step(REG_OPEN_STEP, '0);
    write_step(REG_CLOSE_STEP, STEP_W'(1));
    queue_cmd(OP_MOVE, 8'd0);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_UP, 8'd0);
    queue_cmd(OP_MOVE, 8'd100);
    queue_cmd(OP_TICK, 8'd0);
    queue_cmd(OP_DOWN, 8'd0);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          o_step = STEP_MAX;
          c_step = STEP_W'(1);
        end
        1: begin
          o_step = STEP_W'(1);
          c_step = STEP_MAX;
        end
        2: begin
          o_step = STEP_W'($urandom_range(1, 1677721600));
          c_step = STEP_W'($urandom_range(1, 1677721600));
        end
        default: begin
          // half a percent to twenty percent per tick
          o_step = STEP_W'($urandom_range(32'd1 << 23, 32'd20 << 24));
          c_step = STEP_W'($urandom_range(32'd1 << 23, 32'd20 << 24));
        end
      endcase
      write_step(REG_OPEN_STEP, o_step);
      write_step(REG_CLOSE_STEP, c_step);
      queue_travel(PHASE_BEATS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d command beats and %0d status beats over %0d step writes",
             beats_in, results_seen, reg_writes);
    $display("%0d status beats carried a host report, %0d mismatches",
             reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
